### hw/rtl/chsa_pkg.sv
// Package for the chroma hue/saturation adjust block.
// Holds field widths, register indexes, reset values and the sine/cosine ROM.
// No dependencies.
package chsa_pkg;

  localparam int SAMPLE_W = 8;
  localparam int HUE_W    = 9;
  localparam int GAIN_W   = 8;
  localparam int TRIG_W   = 9;
  localparam int CFG_AW   = 3;

  localparam logic CFG_IDX_HUE = 1'b0;
  localparam logic CFG_IDX_SAT = 1'b1;

  localparam logic signed [HUE_W-1:0] HUE_RESET = '0;
  localparam logic [GAIN_W-1:0]        SAT_RESET = 8'd64;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  // floor(128 * sin(k degrees)), k = 0..90
  localparam logic [7:0] QUARTER_SIN [0:90] = '{
    8'd0,   8'd2,   8'd4,   8'd6,   8'd8,   8'd11,  8'd13,  8'd15,  8'd17,  8'd20,
    8'd22,  8'd24,  8'd26,  8'd28,  8'd30,  8'd33,  8'd35,  8'd37,  8'd39,  8'd41,
    8'd43,  8'd45,  8'd47,  8'd50,  8'd52,  8'd54,  8'd56,  8'd58,  8'd60,  8'd62,
    8'd64,  8'd65,  8'd67,  8'd69,  8'd71,  8'd73,  8'd75,  8'd77,  8'd78,  8'd80,
    8'd82,  8'd83,  8'd85,  8'd87,  8'd88,  8'd90,  8'd92,  8'd93,  8'd95,  8'd96,
    8'd98,  8'd99,  8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd109,
    8'd110, 8'd111, 8'd113, 8'd114, 8'd115, 8'd116, 8'd116, 8'd117, 8'd118, 8'd119,
    8'd120, 8'd121, 8'd121, 8'd122, 8'd123, 8'd123, 8'd124, 8'd124, 8'd125, 8'd125,
    8'd126, 8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127,
    8'd128
  };

  // Sine and cosine (x128, truncated toward zero) for a hue angle in degrees.
  function automatic trig_t hue_trig(input logic signed [HUE_W-1:0] hue);
    logic signed [HUE_W-1:0] h;
    logic [7:0] a;
    logic [7:0] k;
    logic [7:0] s_mag;
    logic [7:0] c_mag;
    logic       c_neg;
    trig_t      t;
    h = hue;
    if (h < -9'sd180) h = -9'sd180;
    if (h > 9'sd180) h = 9'sd180;
    a = h[HUE_W-1] ? 8'(-h) : 8'(h);
    if (a <= 8'd90) begin
      s_mag = QUARTER_SIN[a[6:0]];
      if (a == 8'd30 || a == 8'd90) s_mag = s_mag - 8'd1;
    end else if (a == 8'd180) begin
      s_mag = 8'd0;
    end else begin
      k = 8'd180 - a;
      s_mag = QUARTER_SIN[k[6:0]];
    end
    c_neg = 1'b0;
    if (a < 8'd90) begin
      k = 8'd90 - a;
      c_mag = QUARTER_SIN[k[6:0]];
    end else if (a == 8'd90) begin
      c_mag = 8'd0;
    end else begin
      k = a - 8'd90;
      c_mag = QUARTER_SIN[k[6:0]];
      if (k == 8'd30 || k == 8'd90) c_mag = c_mag - 8'd1;
      c_neg = 1'b1;
    end
    t.sin_v = h[HUE_W-1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    t.cos_v = c_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
    return t;
  endfunction

endpackage

### hw/rtl/chroma_hue_saturation_adjust.sv
// Chroma hue/saturation adjust: 5-stage pipeline, one U,V item per cycle
// while out_tready is high. Each stage holds its item while downstream is
// stalled; the last stage is the output register, so input is still taken
// while a finished item waits, as long as an earlier stage is empty.
// Reset (synchronous, active low) empties the pipeline and sets hue 0, gain 64.
// Depends on chsa_pkg.
module chroma_hue_saturation_adjust (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [7:0] u_in, [15:8] v_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [7:0] u_out, [15:8] v_out
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [chsa_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import chsa_pkg::*;

  logic signed [HUE_W-1:0] hue_r;
  logic [GAIN_W-1:0]       sat_r;
  logic                    cfg_wr;
  trig_t                   trig;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  logic signed [SAMPLE_W-1:0] u1_r, v1s_r;
  logic signed [TRIG_W-1:0]   sin1_r, cos1_r;
  logic signed [16:0]         p_uc, p_vs, p_vc, p_us;
  logic signed [9:0]          uc2_r, vs2_r, vc2_r, us2_r;
  logic signed [10:0]         u3_r, v3s_r;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [19:0]         p_ug, p_vg;
  logic signed [13:0]         u4_r, v4s_r;
  logic signed [15:0]         u_sum, v_sum;
  logic [SAMPLE_W-1:0]        u_clip, v_clip;
  logic [SAMPLE_W-1:0]        u5_r, v5s_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r <= HUE_RESET;
      sat_r <= SAT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == CFG_IDX_HUE) hue_r <= $signed(cfg_pwdata[HUE_W-1:0]);
      if (cfg_paddr[2] == CFG_IDX_SAT) sat_r <= cfg_pwdata[GAIN_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      CFG_IDX_HUE: cfg_prdata = {{(32-HUE_W){hue_r[HUE_W-1]}}, hue_r};
      CFG_IDX_SAT: cfg_prdata = {{(32-GAIN_W){1'b0}}, sat_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // stage enables: advance where the stage is empty or its item moves on
  assign en5       = ~v5_r | out_tready;
  assign en4       = ~v4_r | en5;
  assign en3       = ~v3_r | en4;
  assign en2       = ~v2_r | en3;
  assign en1       = ~v1_r | en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // stage 1: recenter samples, look up sine and cosine
  assign trig = hue_trig(hue_r);

  always_ff @(posedge clk) begin
    if (en1) begin
      u1_r   <= $signed({~in_tdata[7], in_tdata[6:0]});
      v1s_r  <= $signed({~in_tdata[15], in_tdata[14:8]});
      sin1_r <= trig.sin_v;
      cos1_r <= trig.cos_v;
    end
  end

  // stage 2: rotation products, floor shift by 7
  assign p_uc = u1_r * cos1_r;
  assign p_vs = v1s_r * sin1_r;
  assign p_vc = v1s_r * cos1_r;
  assign p_us = u1_r * sin1_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      uc2_r <= 10'(p_uc >>> 7);
      vs2_r <= 10'(p_vs >>> 7);
      vc2_r <= 10'(p_vc >>> 7);
      us2_r <= 10'(p_us >>> 7);
    end
  end

  // stage 3: combine rotated terms
  always_ff @(posedge clk) begin
    if (en3) begin
      u3_r  <= 11'(uc2_r) + 11'(vs2_r);
      v3s_r <= 11'(vc2_r) - 11'(us2_r);
    end
  end

  // stage 4: saturation gain, floor shift by 6
  assign gain_s = $signed({1'b0, sat_r});
  assign p_ug   = u3_r * gain_s;
  assign p_vg   = v3s_r * gain_s;

  always_ff @(posedge clk) begin
    if (en4) begin
      u4_r  <= 14'(p_ug >>> 6);
      v4s_r <= 14'(p_vg >>> 6);
    end
  end

  // stage 5: restore offset, clamp to a byte
  assign u_sum = 16'(u4_r) + 16'sd128;
  assign v_sum = 16'(v4s_r) + 16'sd128;

  always_comb begin
    priority if (u_sum < 16'sd0)   u_clip = 8'd0;
    else if (u_sum > 16'sd255)     u_clip = 8'd255;
    else                           u_clip = u_sum[7:0];
    priority if (v_sum < 16'sd0)   v_clip = 8'd0;
    else if (v_sum > 16'sd255)     v_clip = 8'd255;
    else                           v_clip = v_sum[7:0];
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      u5_r  <= u_clip;
      v5s_r <= v_clip;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {v5s_r, u5_r};

endmodule

### hw/rtl/chsa_checker.sv
// Port-level checker for chroma_hue_saturation_adjust, bound to the top level.
// Observes the input and output stream ports only; no dependencies.
module chsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output item dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output item changed under stall");

endmodule

bind chroma_hue_saturation_adjust chsa_checker u_chsa_checker (.*);

### bench/chroma_adjust_checker.sv
// Checker for the chroma hue/saturation adjust block: tracks register writes,
// predicts each U,V result and compares it with the output stream.
// Depends on chsa_pkg.
module chroma_adjust_checker
  import chsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [15:0]       in_tdata,   // [7:0] u_in, [15:8] v_in
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [15:0]       out_tdata,  // [7:0] u_out, [15:8] v_out
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic              cfg_pready,
  output int                mismatch_count,
  output int                pending_count,
  output int                checked_count
);

  localparam logic [CFG_AW-1:0] HUE_ADDR = CFG_AW'(4 * int'(CFG_IDX_HUE));
  localparam logic [CFG_AW-1:0] SAT_ADDR = CFG_AW'(4 * int'(CFG_IDX_SAT));

  typedef struct packed {
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] u;
  } chroma_t;

  // floor(128 * sin(k degrees)), k = 0..90
  localparam int SINE_QUARTER [0:90] = '{
    0,   2,   4,   6,   8,   11,  13,  15,  17,  20,
    22,  24,  26,  28,  30,  33,  35,  37,  39,  41,
    43,  45,  47,  50,  52,  54,  56,  58,  60,  62,
    64,  65,  67,  69,  71,  73,  75,  77,  78,  80,
    82,  83,  85,  87,  88,  90,  92,  93,  95,  96,
    98,  99,  100, 102, 103, 104, 106, 107, 108, 109,
    110, 111, 113, 114, 115, 116, 116, 117, 118, 119,
    120, 121, 121, 122, 123, 123, 124, 124, 125, 125,
    126, 126, 126, 127, 127, 127, 127, 127, 127, 127,
    128
  };

  logic signed [HUE_W-1:0] hue_shadow;
  logic [GAIN_W-1:0]       gain_shadow;
  chroma_t                 expected_chroma[$];

  // Angles landing just below an exact value lose one step at 30 and 90.
  function automatic int quarter_wave(input int k, input bit short_side);
    int m;
    m = SINE_QUARTER[k];
    if (short_side && (k == 30 || k == 90)) m = m - 1;
    return m;
  endfunction

  function automatic void hue_sin_cos(input logic signed [HUE_W-1:0] hue,
                                      output int s, output int c);
    int h;
    int a;
    h = int'(hue);
    if (h < -180) h = -180;
    if (h > 180) h = 180;
    a = (h < 0) ? -h : h;
    if (a <= 90) s = quarter_wave(a, 1'b1);
    else if (a == 180) s = 0;
    else s = quarter_wave(180 - a, 1'b0);
    if (a < 90) c = quarter_wave(90 - a, 1'b0);
    else if (a == 90) c = 0;
    else c = -quarter_wave(a - 90, 1'b1);
    if (h < 0) s = -s;
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip_byte(input int x);
    if (x < 0) return '0;
    if (x > 255) return 8'd255;
    return SAMPLE_W'(x);
  endfunction

  function automatic chroma_t adjust_chroma(input chroma_t pair,
                                            input logic signed [HUE_W-1:0] hue,
                                            input logic [GAIN_W-1:0] gain);
    int s, c, u, v, u2, v2, g;
    chroma_t r;
    hue_sin_cos(hue, s, c);
    u = int'(pair.u) - 128;
    v = int'(pair.v) - 128;
    g = int'(gain);
    u2 = ((u * c) >>> 7) + ((v * s) >>> 7);
    v2 = ((v * c) >>> 7) - ((u * s) >>> 7);
    r.u = clip_byte(((u2 * g) >>> 6) + 128);
    r.v = clip_byte(((v2 * g) >>> 6) + 128);
    return r;
  endfunction

  always @(posedge clk) begin
    chroma_t want;
    chroma_t got;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      hue_shadow = HUE_RESET;
      gain_shadow = SAT_RESET;
      expected_chroma.delete();
      mismatch_count <= 0;
      checked_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_chroma.size() == 0) begin
          $error("unexpected out item: u_out %0d v_out %0d", got.u, got.v);
          errs = errs + 1;
        end else begin
          want = expected_chroma.pop_front();
          if (got.u !== want.u) begin
            $error("u_out: expected %0d, actual %0d", want.u, got.u);
            errs = errs + 1;
          end
          if (got.v !== want.v) begin
            $error("v_out: expected %0d, actual %0d", want.v, got.v);
            errs = errs + 1;
          end
          checked_count <= checked_count + 1;
        end
      end
      if (in_tvalid && in_tready) begin
        expected_chroma.push_back(adjust_chroma(chroma_t'(in_tdata), hue_shadow, gain_shadow));
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == HUE_ADDR) hue_shadow = cfg_pwdata[HUE_W-1:0];
        else if (cfg_paddr == SAT_ADDR) gain_shadow = cfg_pwdata[GAIN_W-1:0];
      end
      mismatch_count <= mismatch_count + errs;
    end
    pending_count <= expected_chroma.size();
  end

endmodule

### bench/testbench.sv
// Top of the chroma hue/saturation adjust bench: clock, reset, stimulus on the
// input stream and config port, output stall pattern, watchdog and verdict.
// Depends on chsa_pkg, chroma_hue_saturation_adjust and chroma_adjust_checker.
module testbench;
  import chsa_pkg::*;

  localparam logic [CFG_AW-1:0] HUE_ADDR = CFG_AW'(4 * int'(CFG_IDX_HUE));
  localparam logic [CFG_AW-1:0] SAT_ADDR = CFG_AW'(4 * int'(CFG_IDX_SAT));
  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 155;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT = 2000;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;   // [7:0] u_in, [15:8] v_in
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;  // [7:0] u_out, [15:8] v_out
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int quiet_cycles;
  int settings_count;
  bit sender_idle_en;
  bit receiver_idle_en;
  bit hold_request;

  chroma_hue_saturation_adjust DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  chroma_adjust_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic send_chroma(input logic [7:0] u, input logic [7:0] v);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {v, u};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_adjust(input int hue, input int gain);
    write_reg(HUE_ADDR, 32'(hue));
    write_reg(SAT_ADDR, 32'(gain));
    settings_count++;
  endtask

  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_sample();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int random_hue();
    int special_hue [12] = '{0, 30, 90, 120, 180, -180, -30, -90, -120, -150, 60, 150};
    unique case ($urandom_range(0, 7))
      0, 1: return special_hue[$urandom_range(0, 11)];
      2: return $urandom_range(0, 511) - 256;
      default: return $urandom_range(0, 360) - 180;
    endcase
  endfunction

  function automatic int random_gain();
    int special_gain [9] = '{0, 1, 63, 64, 65, 127, 128, 129, 255};
    unique case ($urandom_range(0, 5))
      0: return special_gain[$urandom_range(0, 8)];
      1: return $urandom_range(129, 255);
      default: return $urandom_range(0, 128);
    endcase
  endfunction

  // Output side stall pattern.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (receiver_idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int dir_hue [8] = '{30, 90, 120, 180, -180, 255, -256, -45};
    int dir_gain [8] = '{64, 128, 0, 255, 64, 129, 200, 1};
    logic [7:0] edge_u [6] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd127};
    logic [7:0] edge_v [6] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd129};
    settings_count = 1;
    sender_idle_en = 1'b0;
    receiver_idle_en = 1'b0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 6; i++) send_chroma(edge_u[i], edge_v[i]);
    drain_pipeline();
    for (int i = 0; i < 8; i++) begin
      set_adjust(dir_hue[i], dir_gain[i]);
      send_chroma(8'd0, 8'd255);
      send_chroma(8'd255, 8'd0);
      drain_pipeline();
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_adjust(random_hue(), random_gain());
      sender_idle_en = (p < NUM_PHASES - 3) && (p % 4 != 1);
      receiver_idle_en = (p < NUM_PHASES - 3) && (p % 4 != 2);
      if (p == 2) hold_request = 1'b1;
      repeat (PHASE_ITEMS) send_chroma(random_sample(), random_sample());
      drain_pipeline();
    end

    $display("Checked %0d chroma pairs under %0d hue/gain settings,", checked_count,
             settings_count);
    $display("with out-of-range hues, gains above unity and a long output stall.");
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
